// ===== src/rmts_pkg.sv =====
package rmts_pkg;

    localparam int MaxTasksDef = 16;

    localparam int FuncW = 2;
    localparam int IdW = 22;
    localparam int PeriodW = 16;
    localparam int StatusW = 2;
    localparam int TimeW = 48;
    localparam int StateW = 2;

    // Operation codes.
    localparam logic [FuncW-1:0] FUNC_REG = 2'd0;
    localparam logic [FuncW-1:0] FUNC_DEREG = 2'd1;
    localparam logic [FuncW-1:0] FUNC_YIELD = 2'd2;
    localparam logic [FuncW-1:0] FUNC_TICK = 2'd3;

    // Status codes.
    localparam logic [StatusW-1:0] STS_OK = 2'd0;
    localparam logic [StatusW-1:0] STS_FULL = 2'd1;
    localparam logic [StatusW-1:0] STS_NOT_FOUND = 2'd2;
    localparam logic [StatusW-1:0] STS_MISSED = 2'd3;

    // Slot states.
    localparam logic [StateW-1:0] SL_RUNNING = 2'd1;
    localparam logic [StateW-1:0] SL_READY = 2'd2;
    localparam logic [StateW-1:0] SL_SLEEPING = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input word, clear scan flags
        logic scan;      // process slot at scan index for the operation
        logic demote;    // demote running current task
        logic pick;      // dispatch scan step at scan index
        logic commit;    // make the picked task running
        logic last;      // scan index is at the final slot
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             disp;  // operation asks for a dispatch pass
        logic             done;  // operation ended early (register, yield)
    } t_sts;

endpackage

// ===== src/rmts_ctrl.sv =====
module rmts_ctrl #(
    parameter int MaxTasks = rmts_pkg::MaxTasksDef,
    parameter int IdxW = $clog2(MaxTasks)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rmts_pkg::t_sts    i_sts,
    output rmts_pkg::t_cmd    o_cmd,
    output logic [IdxW-1:0]   o_idx
);
    import rmts_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DEMOTE = 3'd2;
    localparam logic [2:0] S_PICK = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxTasks - 1);

    logic [2:0] r_state, n_state;
    logic [IdxW-1:0] r_idx, n_idx;
    logic w_last;

    assign w_last = (r_idx == LastIdx);
    assign o_idx = r_idx;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // Command decode. Once the operation has ended early, the scan touches
    // no further slot.
    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan = (r_state == S_SCAN) && !i_sts.done;
        o_cmd.demote = (r_state == S_DEMOTE);
        o_cmd.pick = (r_state == S_PICK);
        o_cmd.commit = (r_state == S_COMMIT);
        o_cmd.last = w_last;
    end

    // Sequencer: operation scan, then optional dispatch pass.
    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                n_idx = r_idx + 1'b1;
                if (w_last || i_sts.done) begin
                    n_idx = '0;
                    n_state = S_DEMOTE;
                end
            end
            S_DEMOTE: begin
                n_state = i_sts.disp ? S_PICK : S_OUT;
            end
            S_PICK: begin
                n_idx = r_idx + 1'b1;
                if (w_last) n_state = S_COMMIT;
            end
            S_COMMIT: n_state = S_OUT;
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
        end
    end

endmodule

// ===== src/rmts_dp.sv =====
module rmts_dp #(
    parameter int MaxTasks = rmts_pkg::MaxTasksDef,
    parameter int IdxW = $clog2(MaxTasks)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [rmts_pkg::FuncW-1:0]     i_func,
    input  logic [rmts_pkg::IdW-1:0]       i_task_id,
    input  logic [rmts_pkg::PeriodW-1:0]   i_period_ms,
    input  rmts_pkg::t_cmd                 i_cmd,
    input  logic [IdxW-1:0]                i_idx,
    output rmts_pkg::t_sts                 o_sts,
    output logic [rmts_pkg::StatusW-1:0]   o_status,
    output logic                           o_running_valid,
    output logic [rmts_pkg::IdW-1:0]       o_running_id,
    output logic                           o_dispatched
);
    import rmts_pkg::*;

    // Slot table.
    logic [MaxTasks-1:0] r_valid;
    logic [MaxTasks-1:0] r_armed;
    logic [IdW-1:0]      r_id     [MaxTasks];
    logic [PeriodW-1:0]  r_period [MaxTasks];
    logic [StateW-1:0]   r_sstate [MaxTasks];
    logic [TimeW-1:0]    r_release[MaxTasks];

    logic [TimeW-1:0]    r_now;
    logic [IdxW-1:0]     r_cur;
    logic                r_cur_v;

    // Captured word and per-item flags.
    logic [FuncW-1:0]    r_func;
    logic [IdW-1:0]      r_tid;
    logic [PeriodW-1:0]  r_per;
    logic [StatusW-1:0]  r_status;
    logic                r_hit;
    logic                r_disp;
    logic                r_done;
    logic                r_found;
    logic [IdxW-1:0]     r_best;
    logic [PeriodW-1:0]  r_best_per;

    logic [IdW-1:0]      w_id;
    logic [PeriodW-1:0]  w_per;
    logic [StateW-1:0]   w_st;
    logic [TimeW-1:0]    w_rel;
    logic                w_v;
    logic                w_match;
    logic [TimeW:0]      w_next;

    assign w_v = r_valid[i_idx];
    assign w_id = r_id[i_idx];
    assign w_per = r_period[i_idx];
    assign w_st = r_sstate[i_idx];
    assign w_rel = r_release[i_idx];
    assign w_match = w_v && (w_id == r_tid);
    assign w_next = {1'b0, w_rel} + {{(TimeW + 1 - PeriodW){1'b0}}, w_per};

    assign o_sts.disp = r_disp;
    assign o_sts.done = r_done;

    // Status flags and dispatch bookkeeping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_tid <= i_task_id;
            r_per <= i_period_ms;
            r_status <= STS_OK;
            r_hit <= 1'b0;
            r_done <= 1'b0;
            r_found <= 1'b0;
            r_disp <= (i_func == FUNC_DEREG) || (i_func == FUNC_YIELD);
        end else if (i_cmd.scan) begin
            unique case (r_func)
                FUNC_REG: begin
                    if (!w_v) begin
                        r_done <= 1'b1;
                        r_hit <= 1'b1;
                    end else if (i_cmd.last) begin
                        r_status <= STS_FULL;
                    end
                end
                FUNC_DEREG: begin
                    if (w_match) r_hit <= 1'b1;
                    if (i_cmd.last && !w_match && !r_hit) r_status <= STS_NOT_FOUND;
                end
                FUNC_YIELD: begin
                    if (w_match) begin
                        r_done <= 1'b1;
                        if (w_next <= {1'b0, r_now}) begin
                            r_status <= STS_MISSED;
                            r_disp <= 1'b0;
                        end
                    end else if (i_cmd.last) begin
                        r_status <= STS_NOT_FOUND;
                    end
                end
                FUNC_TICK: begin
                    if (w_v && r_armed[i_idx] && (w_rel <= r_now)) r_disp <= 1'b1;
                end
                default: ;
            endcase
        end else if (i_cmd.pick) begin
            if (w_v && (w_st == SL_READY) && (!r_found || (w_per < r_best_per))) begin
                r_found <= 1'b1;
                r_best <= i_idx;
                r_best_per <= w_per;
            end
        end
    end

    // Table, clock and current-task state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_armed <= '0;
            r_now <= '0;
            r_cur <= '0;
            r_cur_v <= 1'b0;
        end else begin
            if (i_cmd.load && (i_func == FUNC_TICK)) r_now <= r_now + 1'b1;
            if (i_cmd.scan) begin
                unique case (r_func)
                    FUNC_REG: begin
                        if (!w_v) begin
                            r_valid[i_idx] <= 1'b1;
                            r_id[i_idx] <= r_tid;
                            r_period[i_idx] <= r_per;
                            r_sstate[i_idx] <= SL_SLEEPING;
                            r_release[i_idx] <= r_now;
                            r_armed[i_idx] <= 1'b0;
                        end
                    end
                    FUNC_DEREG: begin
                        if (w_match) begin
                            r_valid[i_idx] <= 1'b0;
                            r_armed[i_idx] <= 1'b0;
                            if (r_cur_v && (r_cur == i_idx)) r_cur_v <= 1'b0;
                        end
                    end
                    FUNC_YIELD: begin
                        if (w_match) begin
                            r_sstate[i_idx] <= SL_SLEEPING;
                            if (w_next > {1'b0, r_now}) begin
                                r_release[i_idx] <= w_next[TimeW-1:0];
                                r_armed[i_idx] <= 1'b1;
                            end
                        end
                    end
                    FUNC_TICK: begin
                        if (w_v && r_armed[i_idx] && (w_rel <= r_now)) begin
                            r_sstate[i_idx] <= SL_READY;
                            r_armed[i_idx] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.demote && r_disp && r_cur_v && (r_sstate[r_cur] == SL_RUNNING)) begin
                r_sstate[r_cur] <= SL_READY;
                r_cur_v <= 1'b0;
            end
            if (i_cmd.commit && r_found) begin
                r_sstate[r_best] <= SL_RUNNING;
                r_cur <= r_best;
                r_cur_v <= 1'b1;
            end
        end
    end

    // Result word.
    assign o_status = r_status;
    assign o_running_valid = r_cur_v && r_valid[r_cur] && (r_sstate[r_cur] == SL_RUNNING);
    assign o_running_id = o_running_valid ? r_id[r_cur] : '0;
    assign o_dispatched = r_disp;

endmodule

// ===== src/rate_monotonic_task_scheduler_core.sv =====
// Each item runs an operation scan, which may end early, and then a dispatch
// pass when the operation asks for one; each scan visits one slot per cycle.
// Throughput: one item at a time; the next word is taken after the result
// word leaves. Reset (synchronous, active low) empties the table, clears the
// clock count and the current task.
module rate_monotonic_task_scheduler_core #(
    parameter int MAX_TASKS = rmts_pkg::MaxTasksDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // task_id[21:0], period_ms[37:22]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // status[1:0], running_valid[2],
                                        // running_id[24:3], dispatched[25]
);
    import rmts_pkg::*;

    localparam int IdxW = $clog2(MAX_TASKS);

    t_cmd w_cmd;
    t_sts w_sts;
    logic [IdxW-1:0] w_idx;
    logic [StatusW-1:0] w_status;
    logic w_rv;
    logic [IdW-1:0] w_rid;
    logic w_disp;

    rmts_ctrl #(.MaxTasks(MAX_TASKS), .IdxW(IdxW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_idx(w_idx)
    );

    rmts_dp #(.MaxTasks(MAX_TASKS), .IdxW(IdxW)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_func(s_axis_tuser),
        .i_task_id(s_axis_tdata[21:0]),
        .i_period_ms(s_axis_tdata[37:22]),
        .i_cmd(w_cmd), .i_idx(w_idx), .o_sts(w_sts),
        .o_status(w_status), .o_running_valid(w_rv),
        .o_running_id(w_rid), .o_dispatched(w_disp)
    );

    assign m_axis_tdata = {6'd0, w_disp, w_rid, w_rv, w_status};

    // Input and output never handshake in the same cycle.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output both open");

    // An accepted word is never answered in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result too early");

    // A running id of zero whenever no task runs.
    a_rid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[2]) |-> (m_axis_tdata[24:3] == 22'd0))
        else $error("stale running id");

endmodule
